>>> src/rhc_pkg.sv
// Shared types and constants for the RGB to HSV converter.
// Holds the pipeline payload structs and the fixed-point scale factors; no dependencies.
package rhc_pkg;

  localparam int CHAN_W     = 8;
  localparam int HUE_W      = 15;
  localparam int Q_W        = 13;
  localparam int REM_W      = 9;
  localparam int DEN_W      = 9;
  localparam int HUE_NUM_W  = 22;
  localparam int SAT_NUM_W  = 17;
  localparam int DIV_STEPS  = Q_W;
  localparam int HUE_SCALE  = 7680;
  localparam int SAT_SCALE  = 510;
  localparam logic [HUE_W-1:0] HUE_FULL_TURN = 15'd23040;

  localparam logic [HUE_W-1:0] HUE_BASE_GREEN    = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_BASE_BLUE     = 15'd11520;
  localparam logic [HUE_W-1:0] HUE_BASE_RED_WRAP = 15'd19200;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE,
    SEC_RED_WRAP
  } sector_t;

  typedef struct packed {
    logic [CHAN_W-1:0] value;
    logic [CHAN_W-1:0] span;
    logic signed [CHAN_W:0] diff;
    sector_t sector;
  } front_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0] nq;
    logic [DEN_W-1:0] den;
  } div_t;

  typedef struct packed {
    div_t hue;
    div_t sat;
    sector_t sector;
    logic grey;
    logic black;
    logic [CHAN_W-1:0] value;
  } pix_t;

endpackage

>>> src/rhc_if.sv
// Valid/ready channel interfaces for pixel input and HSV result beats.
// Depends on rhc_pkg for field widths.
interface rhc_in_if;
  logic valid;
  logic ready;
  logic [rhc_pkg::CHAN_W-1:0] red_in;
  logic [rhc_pkg::CHAN_W-1:0] green_in;
  logic [rhc_pkg::CHAN_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface rhc_out_if;
  logic valid;
  logic ready;
  logic [rhc_pkg::HUE_W-1:0] hue_out;
  logic [rhc_pkg::CHAN_W-1:0] saturation_out;
  logic [rhc_pkg::CHAN_W-1:0] value_out;

  modport source (output valid, output hue_out, output saturation_out, output value_out,
                  input ready);
  modport sink (input valid, input hue_out, input saturation_out, input value_out,
                output ready);
endinterface

>>> src/rhc_sort.sv
// First stage: max/min of the three channels, sector choice and signed channel difference.
// Depends on rhc_pkg.
module rhc_sort (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_in,
  input  logic [rhc_pkg::CHAN_W-1:0]  red,
  input  logic [rhc_pkg::CHAN_W-1:0]  green,
  input  logic [rhc_pkg::CHAN_W-1:0]  blue,
  output logic                        vld_out,
  output rhc_pkg::front_t             fr_out
);

  logic [rhc_pkg::CHAN_W-1:0] mx;
  logic [rhc_pkg::CHAN_W-1:0] mn;
  logic signed [rhc_pkg::CHAN_W:0] r_s;
  logic signed [rhc_pkg::CHAN_W:0] g_s;
  logic signed [rhc_pkg::CHAN_W:0] b_s;
  rhc_pkg::front_t fr_nxt;
  rhc_pkg::front_t fr_r;
  logic vld_r;

  assign r_s = $signed({1'b0, red});
  assign g_s = $signed({1'b0, green});
  assign b_s = $signed({1'b0, blue});

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;

    fr_nxt.value = mx;
    fr_nxt.span  = mx - mn;
    if (blue == mx) begin
      fr_nxt.sector = rhc_pkg::SEC_BLUE;
      fr_nxt.diff   = r_s - g_s;
    end else if (green == mx) begin
      fr_nxt.sector = rhc_pkg::SEC_GREEN;
      fr_nxt.diff   = b_s - r_s;
    end else if (green >= blue) begin
      fr_nxt.sector = rhc_pkg::SEC_RED;
      fr_nxt.diff   = g_s - b_s;
    end else begin
      fr_nxt.sector = rhc_pkg::SEC_RED_WRAP;
      fr_nxt.diff   = g_s - b_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fr_r <= fr_nxt;
    end
  end

  assign vld_out = vld_r;
  assign fr_out  = fr_r;

endmodule

>>> src/rhc_prep.sv
// Second stage: builds the hue and saturation dividends and divisors for the divider chain.
// Depends on rhc_pkg.
module rhc_prep (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_in,
  input  rhc_pkg::front_t  fr_in,
  output logic             vld_out,
  output rhc_pkg::pix_t    pix_out
);

  logic signed [rhc_pkg::CHAN_W+1:0] t_s;
  logic [rhc_pkg::CHAN_W:0] t;
  logic [rhc_pkg::HUE_NUM_W-1:0] hue_num;
  logic [rhc_pkg::SAT_NUM_W-1:0] sat_num;
  rhc_pkg::pix_t pix_nxt;
  rhc_pkg::pix_t pix_r;
  logic vld_r;

  // shift the signed difference into 0..2*span for every sector but plain red
  always_comb begin
    if (fr_in.sector == rhc_pkg::SEC_RED) begin
      t_s = {fr_in.diff[rhc_pkg::CHAN_W], fr_in.diff};
    end else begin
      t_s = {fr_in.diff[rhc_pkg::CHAN_W], fr_in.diff} + $signed({2'b00, fr_in.span});
    end
    t = t_s[rhc_pkg::CHAN_W:0];

    hue_num = rhc_pkg::HUE_NUM_W'(t) * rhc_pkg::HUE_NUM_W'(rhc_pkg::HUE_SCALE)
            + rhc_pkg::HUE_NUM_W'(fr_in.span);
    sat_num = rhc_pkg::SAT_NUM_W'(fr_in.span) * rhc_pkg::SAT_NUM_W'(rhc_pkg::SAT_SCALE)
            + rhc_pkg::SAT_NUM_W'(fr_in.value);

    pix_nxt.hue.rem = rhc_pkg::REM_W'(hue_num >> rhc_pkg::Q_W);
    pix_nxt.hue.nq  = hue_num[rhc_pkg::Q_W-1:0];
    pix_nxt.hue.den = {fr_in.span, 1'b0};
    pix_nxt.sat.rem = rhc_pkg::REM_W'(sat_num >> rhc_pkg::Q_W);
    pix_nxt.sat.nq  = sat_num[rhc_pkg::Q_W-1:0];
    pix_nxt.sat.den = {fr_in.value, 1'b0};
    pix_nxt.sector  = fr_in.sector;
    pix_nxt.grey    = (fr_in.span == '0);
    pix_nxt.black   = (fr_in.value == '0);
    pix_nxt.value   = fr_in.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

  assign vld_out = vld_r;
  assign pix_out = pix_r;

endmodule

>>> src/rhc_div_step.sv
// One restoring-division step for both the hue and saturation quotients, registered.
// Depends on rhc_pkg; the quotient bit shifts in as the dividend bit shifts out.
module rhc_div_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_in,
  input  rhc_pkg::pix_t  pix_in,
  output logic           vld_out,
  output rhc_pkg::pix_t  pix_out
);

  function automatic rhc_pkg::div_t step(input rhc_pkg::div_t d);
    logic [rhc_pkg::REM_W:0] rs;
    logic [rhc_pkg::REM_W:0] sub;
    logic ge;
    rhc_pkg::div_t o;
    rs    = {d.rem, d.nq[rhc_pkg::Q_W-1]};
    sub   = rs - {1'b0, d.den};
    ge    = (rs >= {1'b0, d.den});
    o.rem = ge ? sub[rhc_pkg::REM_W-1:0] : rs[rhc_pkg::REM_W-1:0];
    o.nq  = {d.nq[rhc_pkg::Q_W-2:0], ge};
    o.den = d.den;
    return o;
  endfunction

  rhc_pkg::pix_t pix_nxt;
  rhc_pkg::pix_t pix_r;
  logic vld_r;

  always_comb begin
    pix_nxt     = pix_in;
    pix_nxt.hue = step(pix_in.hue);
    pix_nxt.sat = step(pix_in.sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

  assign vld_out = vld_r;
  assign pix_out = pix_r;

endmodule

>>> src/rhc_finish.sv
// Last stage: adds the sector base to the hue quotient, wraps, applies grey/black cases.
// Depends on rhc_pkg; drives the output register.
module rhc_finish (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_in,
  input  rhc_pkg::pix_t               pix_in,
  output logic                        vld_out,
  output logic [rhc_pkg::HUE_W-1:0]   hue,
  output logic [rhc_pkg::CHAN_W-1:0]  sat,
  output logic [rhc_pkg::CHAN_W-1:0]  value
);

  logic [rhc_pkg::HUE_W-1:0] base;
  logic [rhc_pkg::HUE_W-1:0] hue_sum;
  logic [rhc_pkg::HUE_W-1:0] hue_nxt;
  logic [rhc_pkg::CHAN_W-1:0] sat_nxt;
  logic [rhc_pkg::HUE_W-1:0] hue_r;
  logic [rhc_pkg::CHAN_W-1:0] sat_r;
  logic [rhc_pkg::CHAN_W-1:0] value_r;
  logic vld_r;

  always_comb begin
    case (pix_in.sector)
      rhc_pkg::SEC_RED:      base = '0;
      rhc_pkg::SEC_GREEN:    base = rhc_pkg::HUE_BASE_GREEN;
      rhc_pkg::SEC_BLUE:     base = rhc_pkg::HUE_BASE_BLUE;
      rhc_pkg::SEC_RED_WRAP: base = rhc_pkg::HUE_BASE_RED_WRAP;
      default:               base = '0;
    endcase
    hue_sum = base + rhc_pkg::HUE_W'(pix_in.hue.nq);
    if (pix_in.grey) begin
      hue_nxt = '0;
    end else if (hue_sum >= rhc_pkg::HUE_FULL_TURN) begin
      hue_nxt = hue_sum - rhc_pkg::HUE_FULL_TURN;
    end else begin
      hue_nxt = hue_sum;
    end
    sat_nxt = pix_in.black ? '0 : pix_in.sat.nq[rhc_pkg::CHAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      value_r <= pix_in.value;
    end
  end

  assign vld_out = vld_r;
  assign hue     = hue_r;
  assign sat     = sat_r;
  assign value   = value_r;

endmodule

>>> src/rgb_to_hsv_converter_unit.sv
// RGB to HSV converter: 16-stage pipeline, one pixel beat accepted per cycle.
// Stages in order: sort, prepare, 13 divider steps, finish.
// Throughput one beat per cycle, set by the 13 one-bit divider stages running in lockstep.
// A stall at the output freezes every stage; in_bus.ready follows out_bus.ready while the
// output register holds a beat.
// Synchronous active-low reset clears all stage valid bits; payload is not reset.
module rgb_to_hsv_converter_unit (
  input  logic       clk,
  input  logic       rst_n,
  rhc_in_if.sink     in_bus,
  rhc_out_if.source  out_bus
);

  logic advance;
  logic sort_vld;
  rhc_pkg::front_t sort_fr;
  logic [rhc_pkg::DIV_STEPS:0] div_vld;
  rhc_pkg::pix_t div_pix [0:rhc_pkg::DIV_STEPS];
  logic fin_vld;

  assign advance      = !fin_vld || out_bus.ready;
  assign in_bus.ready = advance;

  rhc_sort u_sort (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .vld_in  (in_bus.valid),
    .red     (in_bus.red_in),
    .green   (in_bus.green_in),
    .blue    (in_bus.blue_in),
    .vld_out (sort_vld),
    .fr_out  (sort_fr)
  );

  rhc_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .vld_in  (sort_vld),
    .fr_in   (sort_fr),
    .vld_out (div_vld[0]),
    .pix_out (div_pix[0])
  );

  for (genvar gi = 0; gi < rhc_pkg::DIV_STEPS; gi = gi + 1) begin : g_div
    rhc_div_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (advance),
      .vld_in  (div_vld[gi]),
      .pix_in  (div_pix[gi]),
      .vld_out (div_vld[gi+1]),
      .pix_out (div_pix[gi+1])
    );
  end

  rhc_finish u_finish (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .vld_in  (div_vld[rhc_pkg::DIV_STEPS]),
    .pix_in  (div_pix[rhc_pkg::DIV_STEPS]),
    .vld_out (fin_vld),
    .hue     (out_bus.hue_out),
    .sat     (out_bus.saturation_out),
    .value   (out_bus.value_out)
  );

  assign out_bus.valid = fin_vld;

endmodule

>>> src/rhc_checker.sv
// Port-level checks for the RGB to HSV converter, bound to the top level.
// Depends on rhc_pkg and the top level's channel interfaces.
module rhc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rhc_pkg::HUE_W-1:0]   hue,
  input logic [rhc_pkg::CHAN_W-1:0]  sat,
  input logic [rhc_pkg::CHAN_W-1:0]  value
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(hue) && $stable(sat) && $stable(value))
    else $error("result beat changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready with empty output stage");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> hue < rhc_pkg::HUE_FULL_TURN)
    else $error("hue beyond a full turn");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && value == '0 |-> sat == '0 && hue == '0)
    else $error("black pixel with non-zero hue or saturation");

  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sat == '0 |-> hue == '0)
    else $error("grey pixel with non-zero hue");

endmodule

bind rgb_to_hsv_converter_unit rhc_checker u_rhc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .hue       (out_bus.hue_out),
  .sat       (out_bus.saturation_out),
  .value     (out_bus.value_out)
);
